// ===== rtl/core/psp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Permission spec parser package
// Shared widths, character codes, result codes and the status structures
// passed between the parser sub-blocks and the top level.
// ----------------------------------------------------------------------------
package psp_pkg;

	localparam int CHAR_W           = 8;
	localparam int MODE_W           = 12;
	localparam int SLOT_W           = 3;
	localparam int CLAUSE_SLOTS_DEF = 8;

	// ASCII codes recognised by the two readings.
	localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
	localparam logic [CHAR_W-1:0] CH_7     = 8'h37;
	localparam logic [CHAR_W-1:0] CH_U     = 8'h75;
	localparam logic [CHAR_W-1:0] CH_G     = 8'h67;
	localparam logic [CHAR_W-1:0] CH_O     = 8'h6f;
	localparam logic [CHAR_W-1:0] CH_A     = 8'h61;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
	localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3d;
	localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2c;
	localparam logic [CHAR_W-1:0] CH_R     = 8'h72;
	localparam logic [CHAR_W-1:0] CH_W     = 8'h77;
	localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
	localparam logic [CHAR_W-1:0] CH_S     = 8'h73;
	localparam logic [CHAR_W-1:0] CH_T     = 8'h74;

	typedef enum logic [1:0] {
		OP_PLUS  = 2'd0,
		OP_MINUS = 2'd1,
		OP_EQUAL = 2'd2
	} op_code_t;

	typedef enum logic [1:0] {
		OUT_SYMBOLIC = 2'd0,
		OUT_EXACT    = 2'd1,
		OUT_ERROR    = 2'd2
	} outcome_t;

	typedef struct packed {
		logic              all_octal;
		logic              overflow;
		logic [MODE_W-1:0] value;
	} oct_res_t;

	typedef struct packed {
		logic              emit;
		logic              failed;
		logic [MODE_W-1:0] affected;
		logic [MODE_W-1:0] value;
		op_code_t          op;
		logic [SLOT_W-1:0] slot;
	} sym_res_t;

endpackage

// ===== rtl/core/psp_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Permission spec input channel
// Valid/ready channel carrying one specification character per transaction.
// ----------------------------------------------------------------------------
interface psp_in_if
	import psp_pkg::*;
	();

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] spec_char;
	logic              is_final_char;

	modport source (output valid, output spec_char, output is_final_char, input ready);
	modport sink   (input valid, input spec_char, input is_final_char, output ready);

endinterface

// ===== rtl/core/psp_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Permission spec result channel
// Valid/ready channel carrying one clause and/or final outcome per transaction.
// ----------------------------------------------------------------------------
interface psp_out_if
	import psp_pkg::*;
	();

	logic              valid;
	logic              ready;
	logic              clause_valid;
	logic [MODE_W-1:0] target_bits;
	logic [MODE_W-1:0] perm_bits;
	logic [1:0]        operator_code;
	logic [SLOT_W-1:0] clause_slot;
	logic              spec_done;
	logic [1:0]        outcome;
	logic [MODE_W-1:0] octal_mode;

	modport source (
		output valid, output clause_valid, output target_bits, output perm_bits,
		output operator_code, output clause_slot, output spec_done, output outcome,
		output octal_mode, input ready
	);
	modport sink (
		input valid, input clause_valid, input target_bits, input perm_bits,
		input operator_code, input clause_slot, input spec_done, input outcome,
		input octal_mode, output ready
	);

endinterface

// ===== rtl/core/psp_octal.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Octal reading
// Accumulates a specification made only of digits 0-7 and flags overflow
// past 07777. Presents the state as it stands after the current character.
// ----------------------------------------------------------------------------
module psp_octal
	import psp_pkg::*;
	(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              fin,
	input  logic [CHAR_W-1:0] spec_char,
	output oct_res_t          res
);

	logic              all_q, all_n;
	logic              ovf_q, ovf_n;
	logic [MODE_W-1:0] acc_q, acc_n;
	logic              is_digit;

	assign is_digit = (spec_char >= CH_0) && (spec_char <= CH_7);

	always_comb begin
		all_n = all_q;
		ovf_n = ovf_q;
		acc_n = acc_q;
		if (all_q) begin
			if (is_digit) begin
				// Any bit in the top digit is about to be shifted out.
				if (acc_q[MODE_W-1 -: 3] != 3'd0) begin
					ovf_n = 1'b1;
				end
				acc_n = {acc_q[MODE_W-4:0], spec_char[2:0]};
			end else begin
				all_n = 1'b0;
			end
		end
	end

	assign res.all_octal = all_n;
	assign res.overflow  = ovf_n;
	assign res.value     = acc_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			all_q <= 1'b1;
			ovf_q <= 1'b0;
			acc_q <= '0;
		end else if (step) begin
			if (fin) begin
				all_q <= 1'b1;
				ovf_q <= 1'b0;
				acc_q <= '0;
			end else begin
				all_q <= all_n;
				ovf_q <= ovf_n;
				acc_q <= acc_n;
			end
		end
	end

	// Once a non-digit has been seen the accumulator no longer moves.
	a_acc_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !fin && !all_q) |=> $stable(acc_q) && !all_q)
		else $error("octal accumulator moved after a non-digit");

endmodule

// ===== rtl/core/psp_symbolic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Symbolic reading
// Parses chmod-like clauses (classes, operator, permission letters) and
// reports each clause as it closes, along with the running failure flag.
// ----------------------------------------------------------------------------
module psp_symbolic
	import psp_pkg::*;
	#(
	parameter int CLAUSE_SLOTS = CLAUSE_SLOTS_DEF
	) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              fin,
	input  logic [CHAR_W-1:0] spec_char,
	output sym_res_t          res
);

	localparam int CNT_W = $clog2(CLAUSE_SLOTS + 1);

	localparam logic [2:0] CLS_U   = 3'h1;
	localparam logic [2:0] CLS_G   = 3'h2;
	localparam logic [2:0] CLS_O   = 3'h4;
	localparam logic [2:0] CLS_ALL = 3'h7;

	typedef enum logic {
		PH_WHO,
		PH_PERM
	} phase_t;

	phase_t            phase_q, phase_n;
	logic [2:0]        cls_q, cls_n;
	logic              saw_cls_q, saw_cls_n;
	logic [MODE_W-1:0] pval_q, pval_n;
	op_code_t          pop_q, pop_n;
	logic              saw_perm_q, saw_perm_n;
	logic [CNT_W-1:0]  cnt_q, cnt_n;
	logic              failed_q, failed_n;
	logic              do_close;
	logic              closed_now;
	logic [SLOT_W+CNT_W-1:0] cnt_ext;

	function automatic logic [MODE_W-1:0] class_mask(input logic [2:0] cls);
		logic [MODE_W-1:0] m;
		m = '0;
		if (cls[0]) m = m | 12'o4700;
		if (cls[1]) m = m | 12'o2070;
		if (cls[2]) m = m | 12'o1007;
		return m;
	endfunction

	function automatic logic [MODE_W-1:0] letter_mask(input logic [CHAR_W-1:0] c,
			input logic [2:0] cls);
		logic [MODE_W-1:0] m;
		m = '0;
		priority if (c == CH_R) begin
			m = {3'b000, cls[0], 2'b00, cls[1], 2'b00, cls[2], 2'b00};
		end else if (c == CH_W) begin
			m = {3'b000, 1'b0, cls[0], 2'b00, cls[1], 2'b00, cls[2], 1'b0};
		end else if (c == CH_X) begin
			m = {3'b000, 2'b00, cls[0], 2'b00, cls[1], 2'b00, cls[2]};
		end else if (c == CH_S) begin
			m = {cls[0], cls[1], 1'b0, 9'd0};
		end else begin
			m = {2'b00, cls[2], 9'd0};
		end
		return m;
	endfunction

	assign cnt_ext = {SLOT_W'(0), cnt_q};

	always_comb begin
		phase_n    = phase_q;
		cls_n      = cls_q;
		saw_cls_n  = saw_cls_q;
		pval_n     = pval_q;
		pop_n      = pop_q;
		saw_perm_n = saw_perm_q;
		cnt_n      = cnt_q;
		failed_n   = failed_q;
		do_close   = 1'b0;
		closed_now = 1'b0;
		res.emit     = 1'b0;
		res.affected = '0;
		res.value    = '0;
		res.op       = OP_PLUS;
		res.slot     = '0;

		if (!failed_q) begin
			unique case (phase_q)
				PH_WHO: begin
					priority if (spec_char == CH_U) begin
						cls_n     = cls_q | CLS_U;
						saw_cls_n = 1'b1;
					end else if (spec_char == CH_G) begin
						cls_n     = cls_q | CLS_G;
						saw_cls_n = 1'b1;
					end else if (spec_char == CH_O) begin
						cls_n     = cls_q | CLS_O;
						saw_cls_n = 1'b1;
					end else if (spec_char == CH_A) begin
						cls_n     = CLS_ALL;
						saw_cls_n = 1'b1;
					end else if (spec_char == CH_PLUS || spec_char == CH_MINUS ||
							spec_char == CH_EQ) begin
						if (!saw_cls_q) begin
							cls_n = CLS_ALL;
						end
						priority if (spec_char == CH_PLUS) begin
							pop_n = OP_PLUS;
						end else if (spec_char == CH_MINUS) begin
							pop_n = OP_MINUS;
						end else begin
							pop_n = OP_EQUAL;
						end
						pval_n     = '0;
						saw_perm_n = 1'b0;
						phase_n    = PH_PERM;
					end else begin
						failed_n = 1'b1;
					end
				end
				PH_PERM: begin
					priority if (spec_char == CH_COMMA) begin
						do_close   = 1'b1;
						closed_now = 1'b1;
					end else if (spec_char == CH_R || spec_char == CH_W ||
							spec_char == CH_X || spec_char == CH_S ||
							spec_char == CH_T) begin
						pval_n     = pval_q | letter_mask(spec_char, cls_q);
						saw_perm_n = 1'b1;
					end else begin
						failed_n = 1'b1;
					end
				end
			endcase

			// The last character closes an open clause implicitly.
			if (fin && !failed_n && !closed_now) begin
				if (phase_n == PH_PERM) begin
					do_close = 1'b1;
				end else begin
					failed_n = 1'b1;
				end
			end

			if (do_close) begin
				if (!saw_perm_n || cnt_q >= CNT_W'(CLAUSE_SLOTS)) begin
					failed_n = 1'b1;
				end else begin
					res.emit     = 1'b1;
					res.affected = class_mask(cls_n);
					res.value    = pval_n;
					res.op       = pop_n;
					res.slot     = cnt_ext[SLOT_W-1:0];
					cnt_n        = cnt_q + CNT_W'(1);
					phase_n      = PH_WHO;
					cls_n        = '0;
					saw_cls_n    = 1'b0;
					pval_n       = '0;
					pop_n        = OP_PLUS;
					saw_perm_n   = 1'b0;
				end
			end
		end

		res.failed = failed_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_WHO;
			cls_q      <= '0;
			saw_cls_q  <= 1'b0;
			pval_q     <= '0;
			pop_q      <= OP_PLUS;
			saw_perm_q <= 1'b0;
			cnt_q      <= '0;
			failed_q   <= 1'b0;
		end else if (step) begin
			if (fin) begin
				phase_q    <= PH_WHO;
				cls_q      <= '0;
				saw_cls_q  <= 1'b0;
				pval_q     <= '0;
				pop_q      <= OP_PLUS;
				saw_perm_q <= 1'b0;
				cnt_q      <= '0;
				failed_q   <= 1'b0;
			end else begin
				phase_q    <= phase_n;
				cls_q      <= cls_n;
				saw_cls_q  <= saw_cls_n;
				pval_q     <= pval_n;
				pop_q      <= pop_n;
				saw_perm_q <= saw_perm_n;
				cnt_q      <= cnt_n;
				failed_q   <= failed_n;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CLAUSE_SLOTS))
		else $error("clause count beyond the slot limit");

	a_fin_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(step && fin) |=> (cnt_q == '0) && !failed_q && (phase_q == PH_WHO))
		else $error("symbolic state not restarted after the last character");

endmodule

// ===== rtl/core/permission_spec_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Permission spec parser
// Parses a file permission specification, one character per transaction,
// as both an octal mode and a chmod-style symbolic clause list.
// ----------------------------------------------------------------------------
// The block takes one character per clock cycle and keeps taking one per
// cycle indefinitely as long as the result side does not stall. Each
// accepted character is captured in an input register; in the following
// cycle the octal and symbolic readings update their running state in a
// single pass and, when a clause closes or the character is the last of the
// specification, load one result into the output register, so a result is
// presented from the clock edge after the one that accepted its character,
// unless the result side is holding off. The feedback loop through the
// running parser state is what sets the rate. Characters that produce no
// result are simply absorbed. Clauses are reported as they close; the
// transaction for the last character carries the outcome (exact octal mode,
// symbolic OK or error), and an error outcome means that any clauses already
// reported for that specification must be discarded. After the last
// character both readings return to their reset state, ready for the next
// specification with no gap.
// ----------------------------------------------------------------------------
module permission_spec_parser
	import psp_pkg::*;
	#(
	parameter int CLAUSE_SLOTS = CLAUSE_SLOTS_DEF
	) (
	input  logic       clk,
	input  logic       arst_n,
	psp_in_if.sink     spec,
	psp_out_if.source  result
);

	// Input register stage.
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              fin_s1;

	// Output register.
	logic              out_valid_q;
	logic              clause_valid_q;
	logic [MODE_W-1:0] affected_q;
	logic [MODE_W-1:0] value_q;
	op_code_t          op_q;
	logic [SLOT_W-1:0] slot_q;
	logic              done_q;
	outcome_t          outcome_q;
	logic [MODE_W-1:0] exact_q;

	logic     advance;
	logic     has_result;
	outcome_t outcome_n;
	logic     keep_clause;
	oct_res_t oct_res;
	sym_res_t sym_res;

	// The staged character moves on when the output register is free or is
	// being emptied in this cycle.
	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign spec.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (spec.ready) begin
			valid_s1 <= spec.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (spec.valid && spec.ready) begin
			char_s1 <= spec.spec_char;
			fin_s1  <= spec.is_final_char;
		end
	end

	psp_octal u_octal (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.fin       (fin_s1),
		.spec_char (char_s1),
		.res       (oct_res)
	);

	psp_symbolic #(
		.CLAUSE_SLOTS (CLAUSE_SLOTS)
	) u_symbolic (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.fin       (fin_s1),
		.spec_char (char_s1),
		.res       (sym_res)
	);

	// The octal reading wins whenever every character was a digit; otherwise
	// the symbolic reading decides.
	always_comb begin
		if (oct_res.all_octal) begin
			outcome_n = oct_res.overflow ? OUT_ERROR : OUT_EXACT;
		end else if (sym_res.failed) begin
			outcome_n = OUT_ERROR;
		end else begin
			outcome_n = OUT_SYMBOLIC;
		end
	end

	// A clause that closes on the last character is only reported when the
	// specification as a whole is symbolic and sound.
	assign keep_clause = sym_res.emit && (!fin_s1 || outcome_n == OUT_SYMBOLIC);
	assign has_result  = sym_res.emit || fin_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= has_result;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			clause_valid_q <= keep_clause;
			affected_q     <= keep_clause ? sym_res.affected : '0;
			value_q        <= keep_clause ? sym_res.value : '0;
			op_q           <= keep_clause ? sym_res.op : OP_PLUS;
			slot_q         <= keep_clause ? sym_res.slot : '0;
			done_q         <= fin_s1;
			outcome_q      <= fin_s1 ? outcome_n : OUT_SYMBOLIC;
			exact_q        <= (fin_s1 && outcome_n == OUT_EXACT) ? oct_res.value : '0;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.clause_valid  = clause_valid_q;
	assign result.target_bits   = affected_q;
	assign result.perm_bits     = value_q;
	assign result.operator_code = op_q;
	assign result.clause_slot   = slot_q;
	assign result.spec_done     = done_q;
	assign result.outcome       = outcome_q;
	assign result.octal_mode    = exact_q;

	a_result_has_content: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (clause_valid_q || done_q))
		else $error("result transaction carries neither a clause nor an outcome");

	a_clause_only_symbolic: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && done_q && clause_valid_q) |-> (outcome_q == OUT_SYMBOLIC))
		else $error("clause reported alongside a non-symbolic outcome");

	a_exact_only_when_exact: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && exact_q != '0) |-> (done_q && outcome_q == OUT_EXACT))
		else $error("exact mode present without an exact outcome");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Permission spec parser testbench
// Streams octal, symbolic and malformed permission specifications into the
// parser one character per transaction, predicts every clause and final
// outcome in a scoreboard of its own, and checks each result as it leaves.
// ----------------------------------------------------------------------------
module testbench;
	import psp_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 200_000;
	localparam int unsigned RANDOM_ITEMS = 900;
	localparam int unsigned MAX_REPORTS  = 10;
	localparam int unsigned IDLE_PERCENT = 38;
	localparam int unsigned HOLD_CYCLES  = 300;

	// Class selection bits, one per user class.
	localparam logic [2:0] WHO_U   = 3'b001;
	localparam logic [2:0] WHO_G   = 3'b010;
	localparam logic [2:0] WHO_O   = 3'b100;
	localparam logic [2:0] WHO_ALL = 3'b111;

	localparam logic [CHAR_W-1:0] WHO_CHARS  [4] = '{CH_U, CH_G, CH_O, CH_A};
	localparam logic [CHAR_W-1:0] OP_CHARS   [3] = '{CH_PLUS, CH_MINUS, CH_EQ};
	localparam logic [CHAR_W-1:0] PERM_CHARS [5] = '{CH_R, CH_W, CH_X, CH_S, CH_T};

	// One result transaction, as seen on the output channel.
	typedef struct packed {
		logic              clause_valid;
		logic [MODE_W-1:0] target_bits;
		logic [MODE_W-1:0] perm_bits;
		op_code_t          operator_code;
		logic [SLOT_W-1:0] clause_slot;
		logic              spec_done;
		outcome_t          outcome;
		logic [MODE_W-1:0] octal_mode;
	} parse_result_t;

	// ------------------------------------------------------------------------
	// Scoreboard: tracks both readings of the specification in progress and
	// holds the results that the parser still owes.
	// ------------------------------------------------------------------------
	class perm_spec_board;
		int unsigned slots;
		int unsigned failures;

		// Symbolic reading.
		bit                perm_phase;
		logic [2:0]        classes;
		bit                class_named;
		logic [MODE_W-1:0] value_acc;
		op_code_t          op;
		bit                perm_named;
		int unsigned       n_closed;
		bit                sym_bad;

		// Octal reading.
		bit                octal_only;
		logic [MODE_W-1:0] octal_val;
		bit                octal_ovf;

		parse_result_t expected_parses[$];

		function new(int unsigned clause_slots);
			slots    = clause_slots;
			failures = 0;
			start_spec();
		endfunction

		function void clear_clause();
			perm_phase  = 1'b0;
			classes     = '0;
			class_named = 1'b0;
			value_acc   = '0;
			op          = OP_PLUS;
			perm_named  = 1'b0;
		endfunction

		function void start_spec();
			clear_clause();
			n_closed   = 0;
			sym_bad    = 1'b0;
			octal_only = 1'b1;
			octal_val  = '0;
			octal_ovf  = 1'b0;
		endfunction

		// A clause with no permission letter, or one past the last slot,
		// spoils the symbolic reading instead of being reported.
		function void close_clause(inout parse_result_t r);
			if (!perm_named || n_closed >= slots) begin
				sym_bad = 1'b1;
				return;
			end
			r.clause_valid  = 1'b1;
			r.target_bits   = ({MODE_W{|(classes & WHO_U)}} & 12'o4700)
				| ({MODE_W{|(classes & WHO_G)}} & 12'o2070)
				| ({MODE_W{|(classes & WHO_O)}} & 12'o1007);
			r.perm_bits     = value_acc;
			r.operator_code = op;
			r.clause_slot   = n_closed[SLOT_W-1:0];
			n_closed++;
			clear_clause();
		endfunction

		function void note_char(logic [CHAR_W-1:0] c, logic last);
			parse_result_t r;
			bit            closed;
			logic [2:0]    trip;
			r      = '0;
			closed = 1'b0;

			if (octal_only) begin
				if (c >= CH_0 && c <= CH_7) begin
					if (octal_val[MODE_W-1 -: 3] != 3'b000)
						octal_ovf = 1'b1;
					octal_val = {octal_val[MODE_W-4:0], c[2:0]};
				end else begin
					octal_only = 1'b0;
				end
			end

			if (!sym_bad) begin
				if (!perm_phase) begin
					case (c)
						CH_U: begin classes |= WHO_U; class_named = 1'b1; end
						CH_G: begin classes |= WHO_G; class_named = 1'b1; end
						CH_O: begin classes |= WHO_O; class_named = 1'b1; end
						CH_A: begin classes |= WHO_ALL; class_named = 1'b1; end
						CH_PLUS, CH_MINUS, CH_EQ: begin
							if (!class_named)
								classes = WHO_ALL;
							op = (c == CH_PLUS) ? OP_PLUS
								: (c == CH_MINUS) ? OP_MINUS : OP_EQUAL;
							value_acc  = '0;
							perm_named = 1'b0;
							perm_phase = 1'b1;
						end
						default: sym_bad = 1'b1;
					endcase
				end else begin
					case (c)
						CH_COMMA: begin
							close_clause(r);
							closed = 1'b1;
						end
						CH_R, CH_W, CH_X: begin
							trip = {c == CH_R, c == CH_W, c == CH_X};
							value_acc |= {3'b000,
								|(classes & WHO_U) ? trip : 3'b000,
								|(classes & WHO_G) ? trip : 3'b000,
								|(classes & WHO_O) ? trip : 3'b000};
							perm_named = 1'b1;
						end
						CH_S: begin
							value_acc |= {|(classes & WHO_U), |(classes & WHO_G), 10'b0};
							perm_named = 1'b1;
						end
						CH_T: begin
							value_acc |= {2'b00, |(classes & WHO_O), 9'b0};
							perm_named = 1'b1;
						end
						default: sym_bad = 1'b1;
					endcase
				end
				if (last && !sym_bad && !closed) begin
					if (perm_phase)
						close_clause(r);
					else
						sym_bad = 1'b1;
				end
			end

			if (!r.clause_valid && !last)
				return;

			if (last) begin
				r.spec_done = 1'b1;
				if (octal_only) begin
					if (octal_ovf) begin
						r.outcome = OUT_ERROR;
					end else begin
						r.outcome    = OUT_EXACT;
						r.octal_mode = octal_val;
					end
				end else if (sym_bad) begin
					r.outcome = OUT_ERROR;
				end else begin
					r.outcome = OUT_SYMBOLIC;
				end
				// An exact or failed outcome never carries a clause.
				if (r.outcome != OUT_SYMBOLIC) begin
					r.clause_valid  = 1'b0;
					r.target_bits   = '0;
					r.perm_bits     = '0;
					r.operator_code = OP_PLUS;
					r.clause_slot   = '0;
				end
				start_spec();
			end
			expected_parses.push_back(r);
		endfunction

		function string describe(parse_result_t r);
			return $sformatf(
				"clause=%0b aff=%o val=%o op=%0d slot=%0d done=%0b outcome=%0d exact=%o",
				r.clause_valid, r.target_bits, r.perm_bits, r.operator_code,
				r.clause_slot, r.spec_done, r.outcome, r.octal_mode);
		endfunction

		function void check_result(parse_result_t got);
			parse_result_t want;
			if (expected_parses.size() == 0) begin
				failures++;
				if (failures <= MAX_REPORTS)
					$display("[%0t] result with nothing outstanding: %s",
						$time, describe(got));
				return;
			end
			want = expected_parses.pop_front();
			if (got !== want) begin
				failures++;
				if (failures <= MAX_REPORTS) begin
					$display("[%0t] result mismatch", $time);
					$display("  expected %s", describe(want));
					$display("  actual   %s", describe(got));
				end
			end
		endfunction

		function int unsigned pending();
			return expected_parses.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset, channels and the device under test.
	// ------------------------------------------------------------------------
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always #1 clk = ~clk;

	psp_in_if  spec_if ();
	psp_out_if result_if ();

	permission_spec_parser #(
		.CLAUSE_SLOTS(CLAUSE_SLOTS_DEF)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.spec  (spec_if),
		.result(result_if)
	);

	perm_spec_board   parse_sb;
	logic [CHAR_W-1:0] spec_buf[$];
	int unsigned       items_sent   = 0;
	int unsigned       cycles       = 0;
	// Both sides stop idling while calm is set; squeeze_req asks the
	// receiver for its one long hold-off. Both change by nonblocking
	// assignment so that readers at the same edge see a settled value.
	logic              calm         = 1'b0;
	logic              squeeze_req  = 1'b0;
	bit                squeeze_done = 1'b0;

	// Watchdog: a run that stalls or loses results ends here.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Monitor: every transaction is observed at the clock edge that completes
	// it. A result always belongs to a character accepted at an earlier
	// edge, so checking before noting the new character is safe.
	always @(posedge clk) begin
		parse_result_t got;
		if (arst_n) begin
			if (result_if.valid && result_if.ready) begin
				got.clause_valid  = result_if.clause_valid;
				got.target_bits   = result_if.target_bits;
				got.perm_bits     = result_if.perm_bits;
				got.operator_code = op_code_t'(result_if.operator_code);
				got.clause_slot   = result_if.clause_slot;
				got.spec_done     = result_if.spec_done;
				got.outcome       = outcome_t'(result_if.outcome);
				got.octal_mode    = result_if.octal_mode;
				parse_sb.check_result(got);
			end
			if (spec_if.valid && spec_if.ready)
				parse_sb.note_char(spec_if.spec_char, spec_if.is_final_char);
		end
	end

	// Receiver: drops ready about 38 times in a hundred, never during the
	// calm stretch, and once holds it low for a long run so that the parser
	// backs up and refuses characters.
	initial begin
		result_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (squeeze_req && !squeeze_done) begin
				result_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				squeeze_done = 1'b1;
			end
			result_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
		end
	end

	// Offers one character and returns at the edge where the transaction
	// completes. Random gaps are inserted beforehand, outside the calm stretch.
	task automatic push_char(input logic [CHAR_W-1:0] c, input logic last);
		while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
			spec_if.valid <= 1'b0;
			@(posedge clk);
		end
		spec_if.valid         <= 1'b1;
		spec_if.spec_char     <= c;
		spec_if.is_final_char <= last;
		@(posedge clk);
		while (!spec_if.ready)
			@(posedge clk);
		items_sent++;
		calm        <= (items_sent >= 350 && items_sent < 550);
		squeeze_req <= (items_sent >= 650);
	endtask

	// Sends the buffered specification, flagging its last character.
	task automatic send_spec();
		for (int i = 0; i < spec_buf.size(); i++)
			push_char(spec_buf[i], i == spec_buf.size() - 1);
	endtask

	// Any character of interest to either reading, or a random byte.
	function automatic logic [CHAR_W-1:0] any_char();
		case ($urandom_range(0, 5))
			0:       return WHO_CHARS[$urandom_range(0, 3)];
			1:       return OP_CHARS[$urandom_range(0, 2)];
			2:       return PERM_CHARS[$urandom_range(0, 4)];
			3:       return CH_COMMA;
			4:       return CH_0 + CHAR_W'($urandom_range(0, 9));
			default: return CHAR_W'($urandom_range(0, 255));
		endcase
	endfunction

	// Fills spec_buf with one random specification. Most are well-formed
	// clause lists, so that the deeper states (many clauses, slot overflow,
	// trailing commas) are reached; the rest are octal numbers, broken
	// clause lists and plain noise.
	task automatic build_random_spec();
		int unsigned kind;
		int unsigned n_clauses;
		int unsigned n_letters;
		int unsigned keep;
		kind = $urandom_range(0, 99);
		spec_buf.delete();
		if (kind < 55) begin
			// Usually a few clauses, sometimes enough to run out of slots.
			n_clauses = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 10)
				: $urandom_range(1, 3);
			for (int k = 0; k < n_clauses; k++) begin
				n_letters = $urandom_range(0, 3);
				repeat (n_letters) spec_buf.push_back(WHO_CHARS[$urandom_range(0, 3)]);
				spec_buf.push_back(OP_CHARS[$urandom_range(0, 2)]);
				n_letters = $urandom_range(1, 4);
				repeat (n_letters) spec_buf.push_back(PERM_CHARS[$urandom_range(0, 4)]);
				if (k != n_clauses - 1)
					spec_buf.push_back(CH_COMMA);
			end
			if ($urandom_range(0, 4) == 0)
				spec_buf.push_back(CH_COMMA);
			// Now and then spoil the list: a stray character, or a cut that
			// leaves it ending after class letters, an operator or a comma.
			case ($urandom_range(0, 9))
				0: spec_buf[$urandom_range(0, spec_buf.size() - 1)] = any_char();
				1: begin
					keep = $urandom_range(1, spec_buf.size());
					while (spec_buf.size() > keep)
						void'(spec_buf.pop_back());
				end
				default: ;
			endcase
		end else if (kind < 75) begin
			n_letters = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 6)
				: $urandom_range(1, 4);
			repeat (n_letters) spec_buf.push_back(CH_0 + CHAR_W'($urandom_range(0, 7)));
		end else if (kind < 90) begin
			n_letters = $urandom_range(1, 8);
			repeat (n_letters) spec_buf.push_back(any_char());
		end else begin
			n_letters = $urandom_range(1, 4);
			repeat (n_letters) spec_buf.push_back(CHAR_W'($urandom_range(0, 255)));
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence: reset, directed specifications, random specifications,
	// drain and verdict.
	// ------------------------------------------------------------------------
	initial begin
		parse_sb = new(CLAUSE_SLOTS_DEF);
		spec_if.valid         <= 1'b0;
		spec_if.spec_char     <= '0;
		spec_if.is_final_char <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Largest exact octal mode.
		spec_buf = {CH_7, CH_7, CH_7, CH_7};
		send_spec();
		// Octal value that runs past twelve bits.
		spec_buf = {CH_0 + 8'd1, CH_0, CH_0, CH_0, CH_0};
		send_spec();
		// Two clauses with every user class, set/sticky bits and a
		// trailing comma that closes the last clause.
		spec_buf = {CH_U, CH_G, CH_EQ, CH_R, CH_S, CH_COMMA,
			CH_O, CH_MINUS, CH_X, CH_T, CH_COMMA};
		send_spec();
		// Operator with no permission letter after it.
		spec_buf = {CH_PLUS};
		send_spec();
		// Ends after a class letter.
		spec_buf = {CH_U};
		send_spec();
		// NUL and the top byte value are both bad characters.
		spec_buf = {8'h00};
		send_spec();
		spec_buf = {8'hff};
		send_spec();

		while (items_sent < RANDOM_ITEMS) begin
			build_random_spec();
			send_spec();
		end
		spec_if.valid <= 1'b0;

		// Drain: wait for every outstanding result, then a little longer so
		// that a stray extra transaction would still be caught.
		while (parse_sb.pending() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (parse_sb.failures == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/psp_pkg.sv
rtl/core/psp_in_if.sv
rtl/core/psp_out_if.sv
rtl/core/psp_octal.sv
rtl/core/psp_symbolic.sv
rtl/core/permission_spec_parser.sv
verif/testbench.sv
